[src/hsa_pkg.sv]
// Types, codes and constants shared by the handle slot allocator.
`default_nettype none

package hsa_pkg;

  // Stream widths
  localparam int USER_W     = 2;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 160;

  // Bitmap row geometry: one memory row holds this many used bits
  localparam int COL_N = 32;
  localparam int COL_W = 5;

  localparam logic [31:0] HANDLE_BASE = 32'hFFFF_0000;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_FREE   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_CHK   = 6'b001000,
    S_WR    = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  // Stored words of one slot
  typedef struct packed {
    logic [31:0] share;
    logic [31:0] access;
    logic [31:0] file;
  } ent_t;

  // Result fields apart from the open count
  typedef struct packed {
    status_t     status;
    logic [31:0] handle;
    logic [11:0] slot;
    ent_t        ent;
  } res_t;

  // Build a result; handle and slot are zero when no slot is named
  function automatic res_t mk_res(status_t st, logic has_slot, logic [31:0] slot, ent_t e);
    res_t r;
    r.status = st;
    r.handle = has_slot ? (HANDLE_BASE + slot) : 32'd0;
    r.slot   = has_slot ? slot[11:0] : 12'd0;
    r.ent    = e;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/handle_slot_allocator.sv]
// Handle slot allocator: used bitmap, slot entry memory and request sequencer.
`default_nettype none

// Handle table with NUM_SLOTS slots. One transaction on the in_ channel is one request
// (allocate, lookup, free, clear all) and yields exactly one transaction on the out_
// channel; the block takes one request at a time. The used bits sit in a single-port
// memory of 32-bit rows, and one sequencer reads a row, examines it and writes it back.
// Lookup and free pass through a row read (S_RD) and a check (S_CHK) before the result is
// offered in S_OUT, and the next request is taken once the result is taken (range errors
// and a full table: result offered straight from S_IDLE). Allocate passes through S_RD,
// S_CHK and S_WR before S_OUT, plus one more S_RD and S_CHK per completely used row scanned
// past the lowest row that may hold a free slot. Clear all, and the clearing pass after
// reset, write one bitmap row per cycle through all ceil(NUM_SLOTS/32) rows, 128 at the
// default size, during which no request is taken.
module handle_slot_allocator #(
  parameter int NUM_SLOTS = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [31:0] file_num, [63:32] access_flags, [95:64] share_flags,
  // [127:96] handle_in, [139:128] free_slot, [143:140] zero
  input  wire logic [hsa_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  wire logic [hsa_pkg::USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [31:0] handle_out, [43:32] slot_out, [75:44] file_out, [107:76] access_out,
  // [139:108] share_out, [152:140] open_count, [159:153] zero
  output logic [hsa_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [hsa_pkg::USER_W-1:0]        out_tuser
);
  import hsa_pkg::*;

  localparam int ROWS      = (NUM_SLOTS + COL_N - 1) / COL_N;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W    = ROW_W + COL_W;
  localparam int ENT_AW    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int LAST_BITS = NUM_SLOTS - COL_N * (ROWS - 1);

  // Memories
  logic [COL_N-1:0] bm_mem [ROWS];
  ent_t             ent_mem [NUM_SLOTS];
  logic [COL_N-1:0] bm_q;
  ent_t             ent_q;
  logic             bm_we;
  logic [COL_N-1:0] bm_wdata;
  logic             ent_we;

  // Sequencer state
  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  ent_t              fld_r, fld_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ROW_W-1:0]  hint_r, hint_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              clr_req_r, clr_req_nxt;
  logic [COL_N-1:0]  rowd_r, rowd_nxt;
  res_t              res_r, res_nxt;

  // Helpers
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [COL_N-1:0]  pad;
  logic [COL_N-1:0]  row_vec;
  logic [COL_W-1:0]  first_zero;
  logic [31:0]       hoff;
  logic [31:0]       slot32;
  logic [31:0]       cnt32;
  ent_t              in_ent;
  logic [31:0]       in_handle;
  logic [11:0]       in_free;

  assign row       = slot_r[SLOT_W-1:COL_W];
  assign col       = slot_r[COL_W-1:0];
  assign slot32    = 32'(slot_r);
  assign cnt32     = 32'(cnt_r);
  assign in_ent    = '{share: in_tdata[95:64], access: in_tdata[63:32], file: in_tdata[31:0]};
  assign in_handle = in_tdata[127:96];
  assign in_free   = in_tdata[139:128];
  assign hoff      = in_handle - HANDLE_BASE;

  // Slots past the end of the table in the last row count as used
  always_comb begin
    for (int c = 0; c < COL_N; c++) begin
      pad[c] = (row == ROW_W'(ROWS - 1)) && (c >= LAST_BITS);
    end
    row_vec = bm_q | pad;
  end

  // Lowest free bit of the examined row
  always_comb begin
    first_zero = '0;
    for (int c = COL_N - 1; c >= 0; c--) begin
      if (!row_vec[c]) first_zero = COL_W'(c);
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    fld_nxt     = fld_r;
    slot_nxt    = slot_r;
    hint_nxt    = hint_r;
    cnt_nxt     = cnt_r;
    clr_req_nxt = clr_req_r;
    rowd_nxt    = rowd_r;
    res_nxt     = res_r;
    bm_we       = 1'b0;
    bm_wdata    = '0;
    ent_we      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        bm_we = 1'b1;
        if (row == ROW_W'(ROWS - 1)) begin
          clr_req_nxt = 1'b0;
          if (clr_req_r) begin
            res_nxt   = mk_res(ST_OK, 1'b0, 32'd0, '0);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          slot_nxt = {row + ROW_W'(1), col};
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt = req_t'(in_tuser);
          fld_nxt = in_ent;
          case (req_t'(in_tuser))
            REQ_ALLOC: begin
              if (cnt_r == CNT_W'(NUM_SLOTS)) begin
                res_nxt   = mk_res(ST_FULL, 1'b0, 32'd0, '0);
                state_nxt = S_OUT;
              end else begin
                slot_nxt  = {hint_r, COL_W'(0)};
                state_nxt = S_RD;
              end
            end
            REQ_LOOKUP: begin
              if (in_handle >= HANDLE_BASE && hoff < 32'(NUM_SLOTS)) begin
                slot_nxt  = hoff[SLOT_W-1:0];
                state_nxt = S_RD;
              end else begin
                res_nxt   = mk_res(ST_RANGE, 1'b0, 32'd0, '0);
                state_nxt = S_OUT;
              end
            end
            REQ_FREE: begin
              if (32'(in_free) < 32'(NUM_SLOTS)) begin
                slot_nxt  = SLOT_W'(in_free);
                state_nxt = S_RD;
              end else begin
                res_nxt   = mk_res(ST_RANGE, 1'b0, 32'd0, '0);
                state_nxt = S_OUT;
              end
            end
            REQ_CLEAR: begin
              slot_nxt    = '0;
              clr_req_nxt = 1'b1;
              cnt_nxt     = '0;
              hint_nxt    = '0;
              state_nxt   = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Row read is in flight
      S_RD: state_nxt = S_CHK;

      S_CHK: begin
        case (req_r)
          REQ_ALLOC: begin
            if (&row_vec) begin
              slot_nxt  = {row + ROW_W'(1), COL_W'(0)};
              state_nxt = S_RD;
            end else begin
              slot_nxt  = {row, first_zero};
              rowd_nxt  = bm_q;
              state_nxt = S_WR;
            end
          end
          REQ_LOOKUP: begin
            if (bm_q[col]) res_nxt = mk_res(ST_OK, 1'b1, slot32, ent_q);
            else           res_nxt = mk_res(ST_UNUSED, 1'b0, 32'd0, '0);
            state_nxt = S_OUT;
          end
          REQ_FREE: begin
            if (bm_q[col]) begin
              bm_we    = 1'b1;
              bm_wdata = bm_q & ~(COL_N'(1) << col);
              cnt_nxt  = cnt_r - CNT_W'(1);
              if (row < hint_r) hint_nxt = row;
              res_nxt  = mk_res(ST_OK, 1'b1, slot32, '0);
            end else begin
              res_nxt  = mk_res(ST_UNUSED, 1'b0, 32'd0, '0);
            end
            state_nxt = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      // Claim the found slot and store its words
      S_WR: begin
        bm_we     = 1'b1;
        bm_wdata  = rowd_r | (COL_N'(1) << col);
        ent_we    = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        hint_nxt  = row;
        res_nxt   = mk_res(ST_OK, 1'b1, slot32, fld_r);
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      slot_r    <= '0;
      hint_r    <= '0;
      cnt_r     <= '0;
      clr_req_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      hint_r    <= hint_nxt;
      cnt_r     <= cnt_nxt;
      clr_req_r <= clr_req_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    fld_r  <= fld_nxt;
    rowd_r <= rowd_nxt;
    res_r  <= res_nxt;
  end

  // Used bitmap, one row per address
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[row] <= bm_wdata;
    bm_q <= bm_mem[row];
  end

  // Slot entries
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[slot_r[ENT_AW-1:0]] <= fld_r;
    ent_q <= ent_mem[slot_r[ENT_AW-1:0]];
  end

  // Ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = res_r.status;
  assign out_tdata  = {7'd0, cnt32[12:0], res_r.ent.share, res_r.ent.access,
                       res_r.ent.file, res_r.slot, res_r.handle};

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_SLOTS))
    else $error("open count above table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && req_r == REQ_ALLOC) |-> (32'(row) < 32'(ROWS)))
    else $error("allocate scan ran past the last row");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.status == ST_FULL) |-> (cnt_r == CNT_W'(NUM_SLOTS)))
    else $error("table full reported with free slots");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CNT_W'(1) || cnt_r == $past(cnt_r) - CNT_W'(1) ||
       cnt_r == '0))
    else $error("open count jumped");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request taken while a result is pending");

endmodule

`default_nettype wire
